@@ design/dpbp_pkg.sv @@
// Shared types, widths, register codes and reset values for the back-projection core.
package dpbp_pkg;

    // Pixel index width and output fraction bits
    localparam int COORD_BITS    = 12;
    localparam int OUT_FRAC_BITS = 16;

    // Fixed formats of the fields and registers
    localparam int RECIP_BITS  = 24;
    localparam int CENTER_BITS = 16;
    localparam int CENTER_FRAC = 4;
    localparam int DEPTH_BITS  = 16;
    localparam int COLOR_BITS  = 8;
    localparam int COORD_OUT_W = 32;
    localparam int Z_OUT_W     = 31;

    // Derived datapath widths
    localparam int COORD_Q_W = COORD_BITS + CENTER_FRAC;
    localparam int MAG_W     = (COORD_Q_W > CENTER_BITS) ? COORD_Q_W : CENTER_BITS;
    localparam int DIFF_W    = MAG_W + 1;
    localparam int ZF_W      = DEPTH_BITS + RECIP_BITS;
    localparam int A_W       = MAG_W + RECIP_BITS;
    localparam int P_W       = A_W + ZF_W;
    localparam int SPLIT_W   = 20;
    localparam int LAT_SHIFT = 2 * RECIP_BITS + CENTER_FRAC - OUT_FRAC_BITS;
    localparam int R_W       = P_W - LAT_SHIFT;
    localparam int Z_SHIFT   = RECIP_BITS - OUT_FRAC_BITS;
    localparam int ZR_W      = ZF_W - Z_SHIFT;

    // Saturation limits
    localparam logic [63:0] POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NEG_LIM = 64'h0000_0000_8000_0000;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_INV_DEPTH_SCALE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_INV_FOCAL_X     = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_INV_FOCAL_Y     = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X        = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y        = CFG_INDEX_W'(4);

    localparam logic [RECIP_BITS-1:0]  RST_INV_DEPTH_SCALE = RECIP_BITS'(16777);
    localparam logic [RECIP_BITS-1:0]  RST_INV_FOCAL_X     = RECIP_BITS'(33554);
    localparam logic [RECIP_BITS-1:0]  RST_INV_FOCAL_Y     = RECIP_BITS'(33554);
    localparam logic [CENTER_BITS-1:0] RST_CENTER_X        = CENTER_BITS'(5120);
    localparam logic [CENTER_BITS-1:0] RST_CENTER_Y        = CENTER_BITS'(3840);

    // Camera registers
    typedef struct packed {
        logic [RECIP_BITS-1:0]  inv_depth_scale;
        logic [RECIP_BITS-1:0]  inv_focal_x;
        logic [RECIP_BITS-1:0]  inv_focal_y;
        logic [CENTER_BITS-1:0] center_x;
        logic [CENTER_BITS-1:0] center_y;
    } cfg_t;

    // Input item
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_col;
        logic [COORD_BITS-1:0] pixel_row;
        logic [DEPTH_BITS-1:0] depth_raw;
        logic [COLOR_BITS-1:0] blue_in;
        logic [COLOR_BITS-1:0] green_in;
        logic [COLOR_BITS-1:0] red_in;
    } pixel_t;

    // Result item
    typedef struct packed {
        logic signed [COORD_OUT_W-1:0] point_x;
        logic signed [COORD_OUT_W-1:0] point_y;
        logic [Z_OUT_W-1:0]            point_z;
        logic [COLOR_BITS-1:0]         blue_out;
        logic [COLOR_BITS-1:0]         green_out;
        logic [COLOR_BITS-1:0]         red_out;
    } point_t;

    // Per-item fields that ride alongside the lateral multipliers
    typedef struct packed {
        logic                  neg_x;
        logic                  neg_y;
        logic [Z_OUT_W-1:0]    point_z;
        logic [COLOR_BITS-1:0] blue;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] red;
    } side_t;

endpackage

@@ design/depth_pixel_back_projection_core.sv @@
// Top level of the pinhole depth-pixel back-projection core.
//
// Input channel: an item (column, row, raw depth, BGR color) is taken at each
// rising edge with start high and busy low. busy stays low, so one pixel can be
// presented every cycle for a sustained rate of one item per clock.
// Output channel: point_valid marks point for exactly one cycle; the receiver
// must take it then. A pixel with zero depth gives no result.
// The path is two front stages (depth scale, offset times reciprocal focal)
// and three back stages (partial products, sum, shift and saturate).
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready is always high;
// write only while no item is in flight. Unknown indexes are ignored.
// Reset: rst_n clears all valid bits and loads the default camera registers.
module depth_pixel_back_projection_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  dpbp_pkg::pixel_t                    pixel,
    output logic                                point_valid,
    output dpbp_pkg::point_t                    point,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dpbp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dpbp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dpbp_pkg::cfg_t cfg_reg;
    dpbp_pkg::cfg_t cfg_next;

    logic                              valid2;
    dpbp_pkg::side_t                   side2;
    logic [dpbp_pkg::A_W-1:0]          a_x;
    logic [dpbp_pkg::A_W-1:0]          a_y;
    logic [dpbp_pkg::ZF_W-1:0]         z_full;
    logic [dpbp_pkg::COORD_OUT_W-1:0]  coord_x;
    logic [dpbp_pkg::COORD_OUT_W-1:0]  coord_y;

    logic            valid3_reg;
    logic            valid4_reg;
    logic            valid5_reg;
    dpbp_pkg::side_t side3_reg;
    dpbp_pkg::side_t side4_reg;
    dpbp_pkg::side_t side5_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dpbp_pkg::REG_INV_DEPTH_SCALE: cfg_next.inv_depth_scale = cfg_data;
                dpbp_pkg::REG_INV_FOCAL_X:     cfg_next.inv_focal_x     = cfg_data;
                dpbp_pkg::REG_INV_FOCAL_Y:     cfg_next.inv_focal_y     = cfg_data;
                dpbp_pkg::REG_CENTER_X:
                    cfg_next.center_x = cfg_data[dpbp_pkg::CENTER_BITS-1:0];
                dpbp_pkg::REG_CENTER_Y:
                    cfg_next.center_y = cfg_data[dpbp_pkg::CENTER_BITS-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_depth_scale <= dpbp_pkg::RST_INV_DEPTH_SCALE;
            cfg_reg.inv_focal_x     <= dpbp_pkg::RST_INV_FOCAL_X;
            cfg_reg.inv_focal_y     <= dpbp_pkg::RST_INV_FOCAL_Y;
            cfg_reg.center_x        <= dpbp_pkg::RST_CENTER_X;
            cfg_reg.center_y        <= dpbp_pkg::RST_CENTER_Y;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front stages
    dpbp_prep u_prep (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start && !busy),
        .pixel  (pixel),
        .cfg    (cfg_reg),
        .valid  (valid2),
        .side   (side2),
        .a_x    (a_x),
        .a_y    (a_y),
        .z_full (z_full)
    );

    // Lateral back ends
    dpbp_lateral u_lat_x (
        .clk    (clk),
        .a      (a_x),
        .z_full (z_full),
        .neg    (side2.neg_x),
        .coord  (coord_x)
    );

    dpbp_lateral u_lat_y (
        .clk    (clk),
        .a      (a_y),
        .z_full (z_full),
        .neg    (side2.neg_y),
        .coord  (coord_y)
    );

    // Valid bits alongside the back stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
        end
        else
        begin
            valid3_reg <= valid2;
            valid4_reg <= valid3_reg;
            valid5_reg <= valid4_reg;
        end
    end

    // z and color alongside the back stages
    always_ff @(posedge clk)
    begin
        side3_reg <= side2;
        side4_reg <= side3_reg;
        side5_reg <= side4_reg;
    end

    // Result item
    always_comb
    begin
        point.point_x   = coord_x;
        point.point_y   = coord_y;
        point.point_z   = side5_reg.point_z;
        point.blue_out  = side5_reg.blue;
        point.green_out = side5_reg.green;
        point.red_out   = side5_reg.red;
    end

    assign point_valid = valid5_reg;

    // A point follows every nonzero-depth item
    a_item_to_point: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && pixel.depth_raw != '0) |-> ##5 point_valid)
        else $error("nonzero-depth item produced no point");

    a_point_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> $past(start && !busy && pixel.depth_raw != '0, 5))
        else $error("point without a matching item");

    // Sign of x follows the sign of the column offset
    a_x_sign_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && !side5_reg.neg_x) |-> !point.point_x[dpbp_pkg::COORD_OUT_W-1])
        else $error("nonnegative offset gave negative x");

    a_x_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && side5_reg.neg_x)
            |-> (point.point_x[dpbp_pkg::COORD_OUT_W-1] || point.point_x == '0))
        else $error("negative offset gave positive x");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == dpbp_pkg::REG_CENTER_X)
            |=> cfg_reg.center_x == $past(cfg_data[dpbp_pkg::CENTER_BITS-1:0]))
        else $error("center_x write lost");

endmodule

@@ design/dpbp_prep.sv @@
// Front stages: depth scaling, principal point offsets and offset times reciprocal focal.
module dpbp_prep (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  dpbp_pkg::pixel_t        pixel,
    input  dpbp_pkg::cfg_t          cfg,
    output logic                    valid,
    output dpbp_pkg::side_t         side,
    output logic [dpbp_pkg::A_W-1:0]  a_x,
    output logic [dpbp_pkg::A_W-1:0]  a_y,
    output logic [dpbp_pkg::ZF_W-1:0] z_full
);

    // Stage 1 registers
    logic                              valid1_reg;
    logic [dpbp_pkg::ZF_W-1:0]         zf1_reg;
    logic [dpbp_pkg::MAG_W-1:0]        magx1_reg;
    logic [dpbp_pkg::MAG_W-1:0]        magy1_reg;
    logic                              negx1_reg;
    logic                              negy1_reg;
    logic [dpbp_pkg::COLOR_BITS-1:0]   blue1_reg;
    logic [dpbp_pkg::COLOR_BITS-1:0]   green1_reg;
    logic [dpbp_pkg::COLOR_BITS-1:0]   red1_reg;

    // Stage 2 registers
    logic                              valid2_reg;
    dpbp_pkg::side_t                   side2_reg;
    dpbp_pkg::side_t                   side2_next;
    logic [dpbp_pkg::A_W-1:0]          ax2_reg;
    logic [dpbp_pkg::A_W-1:0]          ay2_reg;
    logic [dpbp_pkg::ZF_W-1:0]         zf2_reg;

    logic [dpbp_pkg::DIFF_W-1:0]       diff_x;
    logic [dpbp_pkg::DIFF_W-1:0]       diff_y;
    logic [dpbp_pkg::DIFF_W-1:0]       abs_x;
    logic [dpbp_pkg::DIFF_W-1:0]       abs_y;
    logic [dpbp_pkg::ZF_W-1:0]         zf1_next;
    logic [dpbp_pkg::ZR_W-1:0]         z_shifted;
    logic [dpbp_pkg::A_W-1:0]          ax2_next;
    logic [dpbp_pkg::A_W-1:0]          ay2_next;

    // Signed Q.4 offsets from the principal point, split into sign and magnitude
    always_comb
    begin
        diff_x = dpbp_pkg::DIFF_W'({pixel.pixel_col, dpbp_pkg::CENTER_FRAC'(0)})
               - dpbp_pkg::DIFF_W'(cfg.center_x);
        diff_y = dpbp_pkg::DIFF_W'({pixel.pixel_row, dpbp_pkg::CENTER_FRAC'(0)})
               - dpbp_pkg::DIFF_W'(cfg.center_y);
        abs_x  = diff_x[dpbp_pkg::DIFF_W-1] ? (~diff_x + 1'b1) : diff_x;
        abs_y  = diff_y[dpbp_pkg::DIFF_W-1] ? (~diff_y + 1'b1) : diff_y;
        zf1_next = dpbp_pkg::ZF_W'(pixel.depth_raw) * dpbp_pkg::ZF_W'(cfg.inv_depth_scale);
    end

    // Stage 1 valid: zero depth drops the item here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= start && (pixel.depth_raw != '0);
            valid2_reg <= valid1_reg;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        zf1_reg    <= zf1_next;
        magx1_reg  <= abs_x[dpbp_pkg::MAG_W-1:0];
        magy1_reg  <= abs_y[dpbp_pkg::MAG_W-1:0];
        negx1_reg  <= diff_x[dpbp_pkg::DIFF_W-1];
        negy1_reg  <= diff_y[dpbp_pkg::DIFF_W-1];
        blue1_reg  <= pixel.blue_in;
        green1_reg <= pixel.green_in;
        red1_reg   <= pixel.red_in;
    end

    // Stage 2: offset times reciprocal focal, z truncated and saturated
    always_comb
    begin
        z_shifted = zf1_reg[dpbp_pkg::ZF_W-1:dpbp_pkg::Z_SHIFT];
        ax2_next  = dpbp_pkg::A_W'(magx1_reg) * dpbp_pkg::A_W'(cfg.inv_focal_x);
        ay2_next  = dpbp_pkg::A_W'(magy1_reg) * dpbp_pkg::A_W'(cfg.inv_focal_y);
        side2_next.neg_x = negx1_reg;
        side2_next.neg_y = negy1_reg;
        side2_next.blue  = blue1_reg;
        side2_next.green = green1_reg;
        side2_next.red   = red1_reg;
        if (64'(z_shifted) > dpbp_pkg::POS_MAX)
            side2_next.point_z = dpbp_pkg::POS_MAX[dpbp_pkg::Z_OUT_W-1:0];
        else
            side2_next.point_z = dpbp_pkg::Z_OUT_W'(z_shifted);
    end

    always_ff @(posedge clk)
    begin
        side2_reg <= side2_next;
        ax2_reg   <= ax2_next;
        ay2_reg   <= ay2_next;
        zf2_reg   <= zf1_reg;
    end

    assign valid  = valid2_reg;
    assign side   = side2_reg;
    assign a_x    = ax2_reg;
    assign a_y    = ay2_reg;
    assign z_full = zf2_reg;

endmodule

@@ design/dpbp_lateral.sv @@
// Back end of one lateral coordinate: split wide product, sum, shift, sign and saturate.
module dpbp_lateral (
    input  logic                               clk,
    input  logic [dpbp_pkg::A_W-1:0]           a,
    input  logic [dpbp_pkg::ZF_W-1:0]          z_full,
    input  logic                               neg,
    output logic [dpbp_pkg::COORD_OUT_W-1:0]   coord
);

    localparam int AH_W = dpbp_pkg::A_W - dpbp_pkg::SPLIT_W;
    localparam int ZH_W = dpbp_pkg::ZF_W - dpbp_pkg::SPLIT_W;
    localparam int SW   = dpbp_pkg::SPLIT_W;

    logic [SW-1:0]            a_lo;
    logic [AH_W-1:0]          a_hi;
    logic [SW-1:0]            z_lo;
    logic [ZH_W-1:0]          z_hi;

    logic [2*SW-1:0]          pp_ll_reg;
    logic [SW+ZH_W-1:0]       pp_lh_reg;
    logic [AH_W+SW-1:0]       pp_hl_reg;
    logic [AH_W+ZH_W-1:0]     pp_hh_reg;
    logic                     neg3_reg;

    logic [dpbp_pkg::P_W-1:0] product_next;
    logic [dpbp_pkg::P_W-1:0] product_reg;
    logic                     neg4_reg;

    logic [dpbp_pkg::R_W-1:0]         mag_r;
    logic [dpbp_pkg::COORD_OUT_W-1:0] coord_next;
    logic [dpbp_pkg::COORD_OUT_W-1:0] coord_reg;

    assign a_lo = a[SW-1:0];
    assign a_hi = a[dpbp_pkg::A_W-1:SW];
    assign z_lo = z_full[SW-1:0];
    assign z_hi = z_full[dpbp_pkg::ZF_W-1:SW];

    // Partial products of the wide magnitude product
    always_ff @(posedge clk)
    begin
        pp_ll_reg <= (2*SW)'(a_lo) * (2*SW)'(z_lo);
        pp_lh_reg <= (SW+ZH_W)'(a_lo) * (SW+ZH_W)'(z_hi);
        pp_hl_reg <= (AH_W+SW)'(a_hi) * (AH_W+SW)'(z_lo);
        pp_hh_reg <= (AH_W+ZH_W)'(a_hi) * (AH_W+ZH_W)'(z_hi);
        neg3_reg  <= neg;
    end

    // Column sum of the partials
    always_comb
    begin
        product_next = (dpbp_pkg::P_W'(pp_hh_reg) << (2*SW))
                     + ((dpbp_pkg::P_W'(pp_lh_reg) + dpbp_pkg::P_W'(pp_hl_reg)) << SW)
                     + dpbp_pkg::P_W'(pp_ll_reg);
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
        neg4_reg    <= neg3_reg;
    end

    // Truncate magnitude toward zero, saturate, apply sign
    always_comb
    begin
        mag_r = product_reg[dpbp_pkg::P_W-1:dpbp_pkg::LAT_SHIFT];
        if (neg4_reg)
        begin
            if (mag_r > dpbp_pkg::R_W'(dpbp_pkg::NEG_LIM))
                coord_next = dpbp_pkg::NEG_LIM[dpbp_pkg::COORD_OUT_W-1:0];
            else
                coord_next = ~mag_r[dpbp_pkg::COORD_OUT_W-1:0] + 1'b1;
        end
        else
        begin
            if (mag_r > dpbp_pkg::R_W'(dpbp_pkg::POS_MAX))
                coord_next = dpbp_pkg::POS_MAX[dpbp_pkg::COORD_OUT_W-1:0];
            else
                coord_next = mag_r[dpbp_pkg::COORD_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        coord_reg <= coord_next;
    end

    assign coord = coord_reg;

endmodule

@@ test/depth_pixel_back_projection_core_tb.sv @@
// Self-checking testbench for the depth-pixel back-projection core.
module depth_pixel_back_projection_core_tb;

    localparam int CLK_HALF      = 6;
    localparam int SETTLE_CYCLES = 10;
    localparam int TIMEOUT_CYCLES = 300000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_SETS   = 8;
    localparam int ITEMS_PER_SET = 100;

    // Fixed-point bookkeeping for the predictor
    localparam int OFFSET_W = dpbp_pkg::COORD_BITS + dpbp_pkg::CENTER_FRAC + 4;
    localparam int ZFULL_W  = dpbp_pkg::DEPTH_BITS + dpbp_pkg::RECIP_BITS;
    localparam int XY_DROP  = 2 * dpbp_pkg::RECIP_BITS + dpbp_pkg::CENTER_FRAC
                            - dpbp_pkg::OUT_FRAC_BITS;
    localparam int Z_DROP   = dpbp_pkg::RECIP_BITS - dpbp_pkg::OUT_FRAC_BITS;
    localparam logic [127:0] XY_POS_LIMIT = 128'h7FFF_FFFF;
    localparam logic [127:0] XY_NEG_LIMIT = 128'h8000_0000;
    localparam logic [dpbp_pkg::Z_OUT_W-1:0] Z_LIMIT = {dpbp_pkg::Z_OUT_W{1'b1}};
    localparam logic [dpbp_pkg::CFG_INDEX_W-1:0] REG_FIRST_UNUSED =
        dpbp_pkg::REG_CENTER_Y + 1'b1;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    dpbp_pkg::pixel_t                 pixel;
    logic                             point_valid;
    dpbp_pkg::point_t                 point;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [dpbp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [dpbp_pkg::CFG_DATA_W-1:0]  cfg_data;

    // Predictor copy of the camera registers and the points still owed
    dpbp_pkg::cfg_t   cam_regs;
    dpbp_pkg::point_t pending_points[$];

    int sender_idle_pct;
    int fail_count;
    int pixels_sent;
    int empty_depth_pixels;
    int points_checked;
    int reg_writes;
    int camera_settings;

    depth_pixel_back_projection_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel       (pixel),
        .point_valid (point_valid),
        .point       (point),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // One lateral coordinate: exact product, magnitude truncated, then saturated
    function automatic logic [dpbp_pkg::COORD_OUT_W-1:0] lateral_coord(
        input logic [dpbp_pkg::COORD_BITS-1:0]  pix,
        input logic [dpbp_pkg::CENTER_BITS-1:0] center,
        input logic [dpbp_pkg::RECIP_BITS-1:0]  inv_f,
        input logic [ZFULL_W-1:0]               z_full
    );
        logic [OFFSET_W-1:0] offset;
        logic                neg;
        logic [OFFSET_W-1:0] mag;
        logic [127:0]        scaled;
        offset = (OFFSET_W'(pix) << dpbp_pkg::CENTER_FRAC) - OFFSET_W'(center);
        neg    = offset[OFFSET_W-1];
        mag    = neg ? -offset : offset;
        scaled = (128'(mag) * 128'(inv_f) * 128'(z_full)) >> XY_DROP;
        if (neg)
        begin
            if (scaled > XY_NEG_LIMIT)
                scaled = XY_NEG_LIMIT;
            return dpbp_pkg::COORD_OUT_W'(0) - scaled[dpbp_pkg::COORD_OUT_W-1:0];
        end
        if (scaled > XY_POS_LIMIT)
            scaled = XY_POS_LIMIT;
        return scaled[dpbp_pkg::COORD_OUT_W-1:0];
    endfunction

    // Expected 3-D point for a pixel with nonzero depth
    function automatic dpbp_pkg::point_t project_pixel(input dpbp_pkg::pixel_t px,
                                                       input dpbp_pkg::cfg_t cam);
        logic [ZFULL_W-1:0] z_full;
        logic [ZFULL_W-1:0] z_q;
        dpbp_pkg::point_t   pt;
        z_full       = ZFULL_W'(px.depth_raw) * ZFULL_W'(cam.inv_depth_scale);
        z_q          = z_full >> Z_DROP;
        pt.point_z   = (z_q > ZFULL_W'(Z_LIMIT)) ? Z_LIMIT : z_q[dpbp_pkg::Z_OUT_W-1:0];
        pt.point_x   = lateral_coord(px.pixel_col, cam.center_x, cam.inv_focal_x, z_full);
        pt.point_y   = lateral_coord(px.pixel_row, cam.center_y, cam.inv_focal_y, z_full);
        pt.blue_out  = px.blue_in;
        pt.green_out = px.green_in;
        pt.red_out   = px.red_in;
        return pt;
    endfunction

    function automatic dpbp_pkg::pixel_t make_pixel(
        input int col, input int row, input int depth,
        input int blue, input int green, input int red
    );
        dpbp_pkg::pixel_t px;
        px.pixel_col = dpbp_pkg::COORD_BITS'(col);
        px.pixel_row = dpbp_pkg::COORD_BITS'(row);
        px.depth_raw = dpbp_pkg::DEPTH_BITS'(depth);
        px.blue_in   = dpbp_pkg::COLOR_BITS'(blue);
        px.green_in  = dpbp_pkg::COLOR_BITS'(green);
        px.red_in    = dpbp_pkg::COLOR_BITS'(red);
        return px;
    endfunction

    function automatic dpbp_pkg::pixel_t random_pixel();
        dpbp_pkg::pixel_t px;
        int               pick;
        pick = $urandom_range(19);
        px   = make_pixel($urandom, $urandom, $urandom_range(1, 65535),
                          $urandom, $urandom, $urandom);
        if (pick < 2)
            px.depth_raw = '0;
        else if (pick == 2)
            px.depth_raw = '1;
        else if (pick < 6)
            px.depth_raw = dpbp_pkg::DEPTH_BITS'($urandom_range(300, 8000));
        return px;
    endfunction

    function automatic logic [dpbp_pkg::RECIP_BITS-1:0] random_recip();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return dpbp_pkg::RECIP_BITS'(1);
        if (pick == 1)
            return '1;
        if (pick < 6)
            return dpbp_pkg::RECIP_BITS'($urandom_range(8000, 70000));
        return dpbp_pkg::RECIP_BITS'($urandom);
    endfunction

    function automatic logic [dpbp_pkg::CENTER_BITS-1:0] random_center();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return dpbp_pkg::CENTER_BITS'($urandom);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%t ERROR %s", $time, msg);
    endfunction

    // Send one pixel, with random sender gaps; returns at a falling edge
    task automatic send_pixel(input dpbp_pkg::pixel_t px);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pixels_sent++;
        if (px.depth_raw != '0)
            pending_points = {pending_points, project_pixel(px, cam_regs)};
        else
            empty_depth_pixels++;
        @(negedge clk);
    endtask

    // Stop sending and let every point in flight come out
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // One register write; the caller lowers cfg_valid after the last one
    task automatic write_reg(input logic [dpbp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dpbp_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_writes++;
        case (idx)
            dpbp_pkg::REG_INV_DEPTH_SCALE:
                cam_regs.inv_depth_scale = data[dpbp_pkg::RECIP_BITS-1:0];
            dpbp_pkg::REG_INV_FOCAL_X:
                cam_regs.inv_focal_x = data[dpbp_pkg::RECIP_BITS-1:0];
            dpbp_pkg::REG_INV_FOCAL_Y:
                cam_regs.inv_focal_y = data[dpbp_pkg::RECIP_BITS-1:0];
            dpbp_pkg::REG_CENTER_X:
                cam_regs.center_x = data[dpbp_pkg::CENTER_BITS-1:0];
            dpbp_pkg::REG_CENTER_Y:
                cam_regs.center_y = data[dpbp_pkg::CENTER_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_camera(input dpbp_pkg::cfg_t cam);
        drain_pipeline();
        write_reg(dpbp_pkg::REG_INV_DEPTH_SCALE, dpbp_pkg::CFG_DATA_W'(cam.inv_depth_scale));
        write_reg(dpbp_pkg::REG_INV_FOCAL_X,     dpbp_pkg::CFG_DATA_W'(cam.inv_focal_x));
        write_reg(dpbp_pkg::REG_INV_FOCAL_Y,     dpbp_pkg::CFG_DATA_W'(cam.inv_focal_y));
        write_reg(dpbp_pkg::REG_CENTER_X,        dpbp_pkg::CFG_DATA_W'(cam.center_x));
        write_reg(dpbp_pkg::REG_CENTER_Y,        dpbp_pkg::CFG_DATA_W'(cam.center_y));
        cfg_valid <= 1'b0;
        camera_settings++;
    endtask

    // Reset camera: corners, principal point, depth extremes, no-depth pixel
    task automatic test_reset_camera();
        send_pixel(make_pixel(0, 0, 1, 0, 0, 0));
        send_pixel(make_pixel(4095, 4095, 65535, 255, 255, 255));
        send_pixel(make_pixel(320, 240, 1000, 170, 85, 15));
        send_pixel(make_pixel(0, 4095, 0, 1, 2, 3));
        send_pixel(make_pixel(4095, 0, 12345, 128, 64, 32));
        send_pixel(make_pixel(321, 239, 1, 90, 180, 240));
        send_pixel(make_pixel(2048, 2048, 32768, 127, 254, 1));
    endtask

    // Largest reciprocals with centers at the ends drive x, y and z to their limits at full depth
    task automatic test_saturation();
        dpbp_pkg::cfg_t cam;
        cam = '{inv_depth_scale: '1, inv_focal_x: '1, inv_focal_y: '1,
                center_x: '0, center_y: '1};
        load_camera(cam);
        send_pixel(make_pixel(4095, 0, 65535, 255, 0, 255));
        send_pixel(make_pixel(0, 4095, 65535, 0, 255, 0));
        cam.center_x = '1;
        cam.center_y = '0;
        load_camera(cam);
        send_pixel(make_pixel(0, 4095, 65535, 17, 34, 51));
        send_pixel(make_pixel(4095, 0, 300, 68, 85, 102));
    endtask

    // Zero reciprocals give zero coordinates; then the smallest legal ones
    task automatic test_small_reciprocals();
        dpbp_pkg::cfg_t cam;
        cam = '{inv_depth_scale: '0, inv_focal_x: '0, inv_focal_y: '0,
                center_x: dpbp_pkg::CENTER_BITS'(5120),
                center_y: dpbp_pkg::CENTER_BITS'(3840)};
        load_camera(cam);
        send_pixel(make_pixel(4095, 0, 65535, 11, 22, 33));
        cam.inv_depth_scale = dpbp_pkg::RECIP_BITS'(16777);
        load_camera(cam);
        send_pixel(make_pixel(0, 4095, 40000, 44, 55, 66));
        cam = '{inv_depth_scale: dpbp_pkg::RECIP_BITS'(1),
                inv_focal_x: dpbp_pkg::RECIP_BITS'(1),
                inv_focal_y: dpbp_pkg::RECIP_BITS'(1), center_x: '0, center_y: '0};
        load_camera(cam);
        send_pixel(make_pixel(4095, 4095, 65535, 77, 88, 99));
        send_pixel(make_pixel(1, 1, 1, 100, 110, 120));
    endtask

    // Writes to indexes past the last register leave the camera unchanged
    task automatic test_unknown_index();
        drain_pipeline();
        for (int i = REG_FIRST_UNUSED; i < (1 << dpbp_pkg::CFG_INDEX_W); i++)
            write_reg(dpbp_pkg::CFG_INDEX_W'(i), dpbp_pkg::CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        send_pixel(make_pixel(4095, 4095, 65535, 200, 150, 100));
        send_pixel(make_pixel(7, 3000, 999, 5, 6, 7));
    endtask

    // Random pixels under random cameras, cycling through sender idle rates
    task automatic test_random_stream();
        int             idle_plan[4];
        dpbp_pkg::cfg_t cam;
        idle_plan = '{0, 56, 6, 56};
        for (int set_no = 0; set_no < RANDOM_SETS; set_no++)
        begin
            cam.inv_depth_scale = random_recip();
            cam.inv_focal_x     = random_recip();
            cam.inv_focal_y     = random_recip();
            cam.center_x        = random_center();
            cam.center_y        = random_center();
            load_camera(cam);
            sender_idle_pct = idle_plan[set_no % 4];
            for (int n = 0; n < ITEMS_PER_SET; n++)
                send_pixel(random_pixel());
        end
        sender_idle_pct = 0;
    endtask

    // Result check: every strobed point against the oldest expected one
    always @(posedge clk)
    begin
        dpbp_pkg::point_t want;
        if (rst_n && point_valid)
        begin
            if (pending_points.size() == 0)
            begin
                note_failure($sformatf("unexpected point x=%0d y=%0d z=%0d",
                                       point.point_x, point.point_y, point.point_z));
            end
            else
            begin
                want = pending_points.pop_front();
                points_checked++;
                if (point.point_x !== want.point_x || point.point_y !== want.point_y ||
                    point.point_z !== want.point_z || point.blue_out !== want.blue_out ||
                    point.green_out !== want.green_out || point.red_out !== want.red_out)
                begin
                    note_failure($sformatf(
                        {"point mismatch exp x=%0d y=%0d z=%0d bgr=%h/%h/%h",
                         " got x=%0d y=%0d z=%0d bgr=%h/%h/%h"},
                        want.point_x, want.point_y, want.point_z,
                        want.blue_out, want.green_out, want.red_out,
                        point.point_x, point.point_y, point.point_z,
                        point.blue_out, point.green_out, point.red_out));
                end
            end
        end
    end

    // Test sequence
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel     = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        sender_idle_pct    = 0;
        fail_count         = 0;
        pixels_sent        = 0;
        empty_depth_pixels = 0;
        points_checked     = 0;
        reg_writes         = 0;
        camera_settings    = 1;
        cam_regs = '{inv_depth_scale: dpbp_pkg::RECIP_BITS'(16777),
                     inv_focal_x: dpbp_pkg::RECIP_BITS'(33554),
                     inv_focal_y: dpbp_pkg::RECIP_BITS'(33554),
                     center_x: dpbp_pkg::CENTER_BITS'(5120),
                     center_y: dpbp_pkg::CENTER_BITS'(3840)};
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_camera();
        test_saturation();
        test_small_reciprocals();
        test_unknown_index();
        test_random_stream();
        drain_pipeline();

        $display("Sent %0d pixels (%0d without depth), checked %0d points",
                 pixels_sent, empty_depth_pixels, points_checked);
        $display("Used %0d camera settings over %0d register writes, sender idle 0/6/56 pct",
                 camera_settings, reg_writes);
        if (fail_count == 0)
            $display("PASS depth_pixel_back_projection_core");
        else
            $display("FAIL depth_pixel_back_projection_core");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("Timed out with %0d points outstanding", pending_points.size());
        $display("FAIL depth_pixel_back_projection_core");
        $finish;
    end

endmodule
